// File: design/distance_vector_route_table_top_defines.svh
// Assertion macros for the route table block
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_TOP_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DVRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dvrt: check failed");
`define DVRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dvrt: check failed");
`else
`define DVRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DVRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/dvrt_pkg.sv
package dvrt_pkg;

    localparam int DEF_ROUTES     = 32;
    localparam int DEF_INTERFACES = 8;
    localparam int DEF_IGNORED    = 32;

    localparam int ADDR_W  = 32;
    localparam int PLEN_W  = 6;
    localparam int DIST_W  = 32;
    localparam int TIMER_W = 16;
    localparam int IDX_W   = 3;

    localparam logic [ADDR_W-1:0]  ALL_ONES    = 32'hffff_ffff;
    localparam logic [PLEN_W-1:0]  MAX_PLEN    = 6'd32;
    localparam logic [DIST_W-1:0]  RST_UNREACH = 32'd16;
    localparam logic [TIMER_W-1:0] RST_IF_TO   = 16'd5;
    localparam logic [TIMER_W-1:0] RST_DEL_TO  = 16'd5;

    localparam logic [1:0] REG_UNREACH     = 2'd0;
    localparam logic [1:0] REG_IF_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_DEL_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD_IF = 2'd0,
        OP_ADVERT = 2'd1,
        OP_TICK   = 2'd2,
        OP_SEND   = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_IF,
        S_SD_SCAN,
        S_SD_WRITE,
        S_RA_IF,
        S_RA_SCAN,
        S_RA_DEC,
        S_IG_SCAN,
        S_IG_END,
        S_RA_SUM,
        S_RA_SUM2,
        S_RA_WR_R,
        S_RA_WR_NR,
        S_TK_IF,
        S_MARK,
        S_AD_CHK,
        S_AD_FIRST,
        S_AD_EMIT0,
        S_AD_SCAN
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  network;
        logic [PLEN_W-1:0]  prefix_len;
        logic [DIST_W-1:0]  distance;
        logic [IDX_W-1:0]   interface_index;
        logic               link_up;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  route_network;
        logic [PLEN_W-1:0]  route_prefix;
        logic [DIST_W-1:0]  route_distance;
        logic [ADDR_W-1:0]  destination;
        logic               last;
    } t_result;

    function automatic logic [ADDR_W-1:0] mask_of(input logic [PLEN_W-1:0] plen);
        if (plen == '0) begin
            return '0;
        end else if (plen >= MAX_PLEN) begin
            return ALL_ONES;
        end else begin
            return ALL_ONES << (MAX_PLEN - plen);
        end
    endfunction

    function automatic logic [PLEN_W-1:0] clamp_plen(input logic [PLEN_W-1:0] plen);
        return (plen > MAX_PLEN) ? MAX_PLEN : plen;
    endfunction

endpackage

// File: design/dvrt_sat_unit.sv
module dvrt_sat_unit
    import dvrt_pkg::*;
(
    input  logic [DIST_W-1:0] i_a,
    input  logic [DIST_W-1:0] i_b,
    input  logic [DIST_W-1:0] i_limit,
    output logic [DIST_W-1:0] o_sum
);

    logic [DIST_W:0] sum;

    assign sum   = {1'b0, i_a} + {1'b0, i_b};
    assign o_sum = (sum >= {1'b0, i_limit}) ? i_limit : sum[DIST_W-1:0];

endmodule

// File: design/distance_vector_route_table_top.sv
// Distance-vector route table engine.
// Items enter on i_item when start is high and busy is low; busy stays high
// until the item is fully processed. Results appear only for the advertise
// operation: one per valid route, each on o_result for exactly one cycle
// with o_result_valid, the final one carrying last. The receiver cannot stall.
// Configuration (unreachable distance, interface timeout, route delete
// timeout) is written over the APB port at byte addresses 0, 4 and 8.
// The sequencer walks the tables one entry per cycle:
//   add_interface:  the interface write, then a set-direct pass over routes.
//   receive_advert: a route scan, an ignore-list scan, then sums and writes.
//   tick:           interface aging, then a route mark pass with an
//                   ignore-list scan per deleted route.
//   advertise:      the first result follows the first valid route and one
//                   set-direct pass, the rest one per valid route scanned.
// Reset clears all valid bits and loads the configuration reset values;
// no clearing pass is needed.
`include "distance_vector_route_table_top_defines.svh"
module distance_vector_route_table_top
    import dvrt_pkg::*;
#(
    parameter int ROUTES     = DEF_ROUTES,
    parameter int INTERFACES = DEF_INTERFACES,
    parameter int IGNORED    = DEF_IGNORED
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_result_valid,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW = $clog2(ROUTES);
    localparam int IW = (INTERFACES > 1) ? $clog2(INTERFACES) : 1;
    localparam int GW = (IGNORED > 1) ? $clog2(IGNORED) : 1;
    localparam logic [RW-1:0] RLAST = RW'(ROUTES - 1);
    localparam logic [GW-1:0] GLAST = GW'(IGNORED - 1);
    localparam logic [IDX_W:0] NIF  = (IDX_W + 1)'(INTERFACES);

    // configuration
    logic [DIST_W-1:0]  r_unreach;
    logic [TIMER_W-1:0] r_if_to;
    logic [TIMER_W-1:0] r_del_to;
    logic               cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unreach <= RST_UNREACH;
            r_if_to   <= RST_IF_TO;
            r_del_to  <= RST_DEL_TO;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_UNREACH:     r_unreach <= pwdata;
                REG_IF_TIMEOUT:  r_if_to   <= pwdata[TIMER_W-1:0];
                REG_DEL_TIMEOUT: r_del_to  <= pwdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_UNREACH:     prdata = r_unreach;
            REG_IF_TIMEOUT:  prdata = {16'd0, r_if_to};
            REG_DEL_TIMEOUT: prdata = {16'd0, r_del_to};
            default:         prdata = '0;
        endcase
    end

    // tables
    logic [ROUTES-1:0]     r_rt_valid;
    logic [ROUTES-1:0]     r_rt_direct;
    logic [ADDR_W-1:0]     r_rt_net   [ROUTES];
    logic [PLEN_W-1:0]     r_rt_plen  [ROUTES];
    logic [DIST_W-1:0]     r_rt_dist  [ROUTES];
    logic [ADDR_W-1:0]     r_rt_via   [ROUTES];
    logic [TIMER_W-1:0]    r_rt_timer [ROUTES];

    logic [INTERFACES-1:0] r_if_valid;
    logic [ADDR_W-1:0]     r_if_addr  [INTERFACES];
    logic [ADDR_W-1:0]     r_if_net   [INTERFACES];
    logic [PLEN_W-1:0]     r_if_plen  [INTERFACES];
    logic [DIST_W-1:0]     r_if_cost  [INTERFACES];
    logic [TIMER_W-1:0]    r_if_timer [INTERFACES];

    logic [IGNORED-1:0]    r_ig_valid;
    logic [ADDR_W-1:0]     r_ig_net   [IGNORED];

    // sequencer state
    t_state             r_state, n_state;
    t_item              r_item;
    logic [PLEN_W-1:0]  r_plen;
    logic [RW-1:0]      r_ri, r_i0;
    logic [GW-1:0]      r_gi;
    logic [IW-1:0]      r_fsel;
    logic               r_r_found, r_nr_found, r_f1_found, r_f2_found;
    logic [RW-1:0]      r_r_idx, r_nr_idx, r_f1_idx, r_f2_idx;
    logic [DIST_W-1:0]  r_r_dist;
    logic [ADDR_W-1:0]  r_r_via;
    logic               r_nf_ok;
    logic [ADDR_W-1:0]  r_g_net;
    logic               r_g_drop, r_g_add, r_g_match, r_g_free_found;
    logic [GW-1:0]      r_g_free_idx;
    logic               r_ign_after;
    logic [DIST_W-1:0]  r_nd, r_sum;
    logic [INTERFACES-1:0] r_exp;
    logic               r_down, r_tick, r_more, r_sd_adv;
    t_result            r_stage;
    logic               r_out_valid;
    t_result            r_out;

    logic accept;
    assign accept = start & ~busy;
    assign busy   = (r_state != S_IDLE);

    // current route entry and selected interface
    logic               c_valid, c_direct;
    logic [ADDR_W-1:0]  c_net, c_via;
    logic [PLEN_W-1:0]  c_plen;
    logic [DIST_W-1:0]  c_dist;
    logic [TIMER_W-1:0] c_timer;
    logic [ADDR_W-1:0]  f_net, f_dest;
    logic [PLEN_W-1:0]  f_plen;
    logic [DIST_W-1:0]  f_cost;
    logic [DIST_W-1:0]  c_disp;

    assign c_valid  = r_rt_valid[r_ri];
    assign c_direct = r_rt_direct[r_ri];
    assign c_net    = r_rt_net[r_ri];
    assign c_via    = r_rt_via[r_ri];
    assign c_plen   = r_rt_plen[r_ri];
    assign c_dist   = r_rt_dist[r_ri];
    assign c_timer  = r_rt_timer[r_ri];
    assign f_net    = r_if_net[r_fsel];
    assign f_plen   = r_if_plen[r_fsel];
    assign f_cost   = r_if_cost[r_fsel];
    assign f_dest   = f_net | ~mask_of(f_plen);
    assign c_disp   = (c_dist >= r_unreach) ? ALL_ONES : c_dist;

    // shared saturating adder
    logic [DIST_W-1:0] s_a, s_b, s_sum;

    assign s_a = (r_state == S_RA_SUM2) ? r_nd : f_cost;
    assign s_b = (r_state == S_RA_SUM2) ? r_item.distance : '0;

    dvrt_sat_unit u_sat (
        .i_a     (s_a),
        .i_b     (s_b),
        .i_limit (r_unreach),
        .o_sum   (s_sum)
    );

    // interface checks
    logic               af_found, own_hit, nf_found;
    logic [IW-1:0]      af_idx, nf_idx;
    logic [TIMER_W-1:0] t_new [INTERFACES];
    logic [INTERFACES-1:0] t_exp;
    logic [IW-1:0]      ad_idx;
    logic               ad_ok;

    always_comb begin
        af_found = 1'b0;
        af_idx   = '0;
        own_hit  = 1'b0;
        nf_found = 1'b0;
        nf_idx   = '0;
        for (int f = 0; f < INTERFACES; f++) begin
            if (!af_found && !r_if_valid[f]) begin
                af_found = 1'b1;
                af_idx   = IW'(f);
            end
            if (r_if_valid[f] && r_if_addr[f] == r_item.address) begin
                own_hit = 1'b1;
            end
            if (!nf_found && r_if_valid[f]
                && (r_item.address & mask_of(r_if_plen[f])) == r_if_net[f]) begin
                nf_found = 1'b1;
                nf_idx   = IW'(f);
            end
            t_new[f] = (r_if_timer[f] != '0) ? r_if_timer[f] - 16'd1 : r_if_timer[f];
            t_exp[f] = r_if_valid[f] && (t_new[f] == '0);
        end
    end

    assign ad_idx = r_item.interface_index[IW-1:0];
    assign ad_ok  = ({1'b0, r_item.interface_index} < NIF) && r_if_valid[ad_idx]
                    && (|r_rt_valid);

    // mark and age logic on the current route
    logic               cov_any, m_hit, m_del, m_dec;
    logic [DIST_W-1:0]  m_dist;
    logic [TIMER_W-1:0] m_timer;

    always_comb begin
        cov_any = 1'b0;
        for (int f = 0; f < INTERFACES; f++) begin
            if (r_exp[f] && (c_via & mask_of(r_if_plen[f])) == r_if_net[f]) begin
                cov_any = 1'b1;
            end
        end
        m_hit   = c_valid && (c_dist < r_unreach)
                  && ((!c_direct && cov_any) || (r_down && c_direct && c_net == f_net));
        m_dist  = m_hit ? r_unreach : c_dist;
        m_timer = m_hit ? r_del_to : c_timer;
        m_del   = r_tick && c_valid && (m_dist >= r_unreach) && (m_timer <= 16'd1);
        m_dec   = r_tick && c_valid && (m_dist >= r_unreach) && !m_del;
    end

    // valid routes above a position
    logic above_ri, above_i0;

    always_comb begin
        above_ri = 1'b0;
        above_i0 = 1'b0;
        for (int j = 0; j < ROUTES; j++) begin
            if (r_rt_valid[j] && RW'(j) > r_ri) above_ri = 1'b1;
            if (r_rt_valid[j] && RW'(j) > r_i0) above_i0 = 1'b1;
        end
    end

    // scan matches
    logic sc_match, sc_cover, sd_match, g_hit;

    assign sc_match = c_valid && (c_net == r_item.network);
    assign sc_cover = c_valid && ((r_item.address & mask_of(c_plen)) == c_net);
    assign sd_match = c_valid && (c_net == f_net);
    assign g_hit    = r_ig_valid[r_gi] && (r_ig_net[r_gi] == r_g_net);

    // route write port
    logic               we_valid, we_net, we_plen, we_dist, we_direct, we_via, we_timer;
    logic [RW-1:0]      rw_idx;
    logic               w_valid, w_direct;
    logic [ADDR_W-1:0]  w_net, w_via;
    logic [PLEN_W-1:0]  w_plen;
    logic [DIST_W-1:0]  w_dist;
    logic [TIMER_W-1:0] w_timer;
    logic               nr_ok, r_new_taken;
    logic [RW-1:0]      nr_idx;
    logic [PLEN_W-1:0]  np;

    assign r_new_taken = !r_r_found && r_f1_found;
    assign nr_ok  = r_nr_found || (r_new_taken ? r_f2_found : r_f1_found);
    assign nr_idx = r_nr_found ? r_nr_idx : (r_new_taken ? r_f2_idx : r_f1_idx);
    assign np     = r_nf_ok ? f_plen : '0;

    always_comb begin
        we_valid = 1'b0; we_net = 1'b0; we_plen = 1'b0; we_dist = 1'b0;
        we_direct = 1'b0; we_via = 1'b0; we_timer = 1'b0;
        rw_idx = r_ri;
        w_valid = 1'b1; w_direct = 1'b0; w_net = f_net; w_via = '0;
        w_plen = f_plen; w_dist = s_sum; w_timer = r_del_to;
        unique case (r_state)
            S_SD_WRITE: begin
                if (r_r_found || r_f1_found) begin
                    rw_idx = r_r_found ? r_r_idx : r_f1_idx;
                    {we_valid, we_net, we_plen, we_dist} = 4'hf;
                    {we_direct, we_via, we_timer} = 3'h7;
                    w_direct = 1'b1;
                end
            end
            S_RA_WR_R: begin
                w_plen = r_plen;
                w_dist = r_sum;
                w_net  = r_item.network;
                w_via  = r_item.address;
                if (r_r_found) begin
                    rw_idx   = r_r_idx;
                    we_plen  = 1'b1;
                    we_timer = (r_sum < r_unreach) || r_ign_after;
                    if (r_item.address == r_r_via) begin
                        we_direct = 1'b1;
                        we_dist   = 1'b1;
                    end else if (r_sum < r_r_dist) begin
                        we_direct = 1'b1;
                        we_dist   = 1'b1;
                        we_via    = 1'b1;
                    end
                end else if (r_f1_found) begin
                    rw_idx = r_f1_idx;
                    {we_valid, we_net, we_plen, we_dist} = 4'hf;
                    {we_direct, we_via, we_timer} = 3'h7;
                end
            end
            S_RA_WR_NR: begin
                rw_idx   = nr_idx;
                w_dist   = r_nd;
                w_direct = 1'b1;
                w_plen   = np;
                w_net    = r_item.address & mask_of(np);
                if (nr_ok) begin
                    {we_dist, we_direct, we_plen, we_net} = 4'hf;
                    we_valid = !r_nr_found;
                    we_via   = !r_nr_found;
                    we_timer = !r_nr_found;
                end
            end
            S_MARK: begin
                w_dist  = m_dist;
                w_valid = 1'b0;
                w_timer = m_dec ? m_timer - 16'd1 : m_timer;
                if (c_valid) begin
                    we_dist  = 1'b1;
                    we_timer = 1'b1;
                    we_valid = m_del;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_valid <= '0;
        end else if (we_valid) begin
            r_rt_valid[rw_idx] <= w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_net)    r_rt_net[rw_idx]    <= w_net;
        if (we_plen)   r_rt_plen[rw_idx]   <= w_plen;
        if (we_dist)   r_rt_dist[rw_idx]   <= w_dist;
        if (we_direct) r_rt_direct[rw_idx] <= w_direct;
        if (we_via)    r_rt_via[rw_idx]    <= w_via;
        if (we_timer)  r_rt_timer[rw_idx]  <= w_timer;
    end

    // interface table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_valid <= '0;
        end else if (r_state == S_ADD_IF && af_found) begin
            r_if_valid[af_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_ADD_IF: begin
                if (af_found) begin
                    r_if_addr[af_idx]  <= r_item.address;
                    r_if_plen[af_idx]  <= r_plen;
                    r_if_net[af_idx]   <= r_item.address & mask_of(r_plen);
                    r_if_cost[af_idx]  <= r_item.distance;
                    r_if_timer[af_idx] <= r_if_to;
                end
            end
            S_RA_IF: begin
                if (!own_hit && nf_found) r_if_timer[nf_idx] <= r_if_to;
            end
            S_TK_IF: begin
                for (int f = 0; f < INTERFACES; f++) begin
                    if (r_if_valid[f]) r_if_timer[f] <= t_new[f];
                end
            end
            S_AD_CHK: begin
                if (ad_ok && !r_item.link_up) r_if_timer[ad_idx] <= '0;
            end
            default: ;
        endcase
    end

    // ignore list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ig_valid <= '0;
        end else if (r_state == S_IG_SCAN && r_g_drop && g_hit) begin
            r_ig_valid[r_gi] <= 1'b0;
        end else if (r_state == S_IG_END && !r_g_drop && !r_g_match && r_g_free_found) begin
            r_ig_valid[r_g_free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IG_END && !r_g_drop && !r_g_match && r_g_free_found) begin
            r_ig_net[r_g_free_idx] <= r_g_net;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.operation)
                        OP_ADD_IF: n_state = S_ADD_IF;
                        OP_ADVERT: n_state = S_RA_IF;
                        OP_TICK:   n_state = S_TK_IF;
                        OP_SEND:   n_state = S_AD_CHK;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_IF:   n_state = af_found ? S_SD_SCAN : S_IDLE;
            S_SD_SCAN:  if (r_ri == RLAST) n_state = S_SD_WRITE;
            S_SD_WRITE: n_state = r_sd_adv ? S_AD_EMIT0 : S_IDLE;
            S_RA_IF:    n_state = own_hit ? S_IDLE : S_RA_SCAN;
            S_RA_SCAN:  if (r_ri == RLAST) n_state = S_RA_DEC;
            S_RA_DEC: begin
                n_state = (r_item.distance >= r_unreach && !r_r_found) ? S_IDLE : S_IG_SCAN;
            end
            S_IG_SCAN:  if (r_gi == GLAST) n_state = S_IG_END;
            S_IG_END: begin
                if (r_tick) begin
                    n_state = r_more ? S_MARK : S_IDLE;
                end else begin
                    n_state = (r_g_add && r_g_match) ? S_IDLE : S_RA_SUM;
                end
            end
            S_RA_SUM:   n_state = S_RA_SUM2;
            S_RA_SUM2:  n_state = S_RA_WR_R;
            S_RA_WR_R:  n_state = S_RA_WR_NR;
            S_RA_WR_NR: n_state = S_IDLE;
            S_TK_IF:    n_state = S_MARK;
            S_MARK: begin
                if (m_del) begin
                    n_state = S_IG_SCAN;
                end else if (r_ri == RLAST) begin
                    n_state = S_IDLE;
                end
            end
            S_AD_CHK: begin
                if (!ad_ok) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = r_item.link_up ? S_AD_FIRST : S_MARK;
                end
            end
            S_AD_FIRST: if (c_valid) n_state = S_SD_SCAN;
            S_AD_EMIT0: n_state = (r_i0 == RLAST) ? S_IDLE : S_AD_SCAN;
            S_AD_SCAN:  if (r_ri == RLAST) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_item     <= i_item;
                    r_plen     <= clamp_plen(i_item.prefix_len);
                    r_ri       <= '0;
                    r_gi       <= '0;
                    r_r_found  <= 1'b0;
                    r_nr_found <= 1'b0;
                    r_f1_found <= 1'b0;
                    r_f2_found <= 1'b0;
                    r_tick     <= (i_item.operation == OP_TICK);
                end
            end
            S_ADD_IF: begin
                r_fsel   <= af_idx;
                r_sd_adv <= 1'b0;
            end
            S_SD_SCAN: begin
                if (sd_match && !r_r_found) begin
                    r_r_found <= 1'b1;
                    r_r_idx   <= r_ri;
                end
                if (!c_valid && !r_f1_found) begin
                    r_f1_found <= 1'b1;
                    r_f1_idx   <= r_ri;
                end
                r_ri <= r_ri + RW'(1);
            end
            S_RA_IF: begin
                r_nf_ok <= nf_found;
                r_fsel  <= nf_idx;
            end
            S_RA_SCAN: begin
                if (sc_match && !r_r_found) begin
                    r_r_found <= 1'b1;
                    r_r_idx   <= r_ri;
                    r_r_dist  <= c_dist;
                    r_r_via   <= c_via;
                end
                if (sc_cover && !r_nr_found) begin
                    r_nr_found <= 1'b1;
                    r_nr_idx   <= r_ri;
                end
                if (!c_valid) begin
                    if (!r_f1_found) begin
                        r_f1_found <= 1'b1;
                        r_f1_idx   <= r_ri;
                    end else if (!r_f2_found) begin
                        r_f2_found <= 1'b1;
                        r_f2_idx   <= r_ri;
                    end
                end
                r_ri <= r_ri + RW'(1);
            end
            S_RA_DEC: begin
                r_g_net        <= r_item.network;
                r_g_add        <= (r_item.distance >= r_unreach) && (r_r_dist >= r_unreach);
                r_g_drop       <= !((r_item.distance >= r_unreach) && (r_r_dist >= r_unreach));
                r_g_match      <= 1'b0;
                r_g_free_found <= 1'b0;
                r_gi           <= '0;
            end
            S_IG_SCAN: begin
                if (g_hit) r_g_match <= 1'b1;
                if (!r_ig_valid[r_gi] && !r_g_free_found) begin
                    r_g_free_found <= 1'b1;
                    r_g_free_idx   <= r_gi;
                end
                r_gi <= r_gi + GW'(1);
            end
            S_IG_END: begin
                r_ign_after <= r_g_add && !r_g_match && r_g_free_found;
            end
            S_RA_SUM:  r_nd  <= r_nf_ok ? s_sum : r_unreach;
            S_RA_SUM2: r_sum <= s_sum;
            S_TK_IF: begin
                r_exp  <= t_exp;
                r_down <= 1'b0;
                r_ri   <= '0;
            end
            S_MARK: begin
                if (m_del) begin
                    r_more         <= (r_ri != RLAST);
                    r_g_net        <= c_net;
                    r_g_drop       <= 1'b0;
                    r_g_add        <= 1'b0;
                    r_g_match      <= 1'b0;
                    r_g_free_found <= 1'b0;
                    r_gi           <= '0;
                end
                r_ri <= r_ri + RW'(1);
            end
            S_AD_CHK: begin
                r_fsel <= ad_idx;
                r_exp  <= '0;
                r_exp[ad_idx] <= 1'b1;
                r_down <= 1'b1;
                r_ri   <= '0;
            end
            S_AD_FIRST: begin
                if (c_valid) begin
                    r_i0     <= r_ri;
                    r_sd_adv <= 1'b1;
                    r_stage  <= '{route_network: c_net, route_prefix: c_plen,
                                  route_distance: c_disp, destination: f_dest,
                                  last: 1'b0};
                    r_ri     <= '0;
                end else begin
                    r_ri <= r_ri + RW'(1);
                end
            end
            S_AD_EMIT0: r_ri <= r_i0 + RW'(1);
            S_AD_SCAN:  r_ri <= r_ri + RW'(1);
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == S_AD_EMIT0) || (r_state == S_AD_SCAN && c_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_AD_EMIT0) begin
            r_out      <= r_stage;
            r_out.last <= !above_i0;
        end else if (r_state == S_AD_SCAN && c_valid) begin
            r_out <= '{route_network: c_net, route_prefix: c_plen,
                       route_distance: c_disp, destination: f_dest,
                       last: !above_ri};
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    `DVRT_ASSERT_IMP(a_more_after_emit, i_clk, i_rst_n, r_out_valid && !r_out.last, r_state == S_AD_SCAN)
    `DVRT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, accept, busy)
    `DVRT_ASSERT_NXT(a_iface_only_on_add, i_clk, i_rst_n, r_state != S_ADD_IF, r_if_valid == $past(r_if_valid))

endmodule

// File: test/distance_vector_route_table_top_tb.sv
module distance_vector_route_table_top_tb;
    import dvrt_pkg::*;

    localparam int NR = DEF_ROUTES;
    localparam int NF = DEF_INTERFACES;
    localparam int NI = DEF_IGNORED;

    class route_scoreboard;
        bit [31:0] unreach;
        bit [15:0] if_to;
        bit [15:0] del_to;
        bit        r_ok[NR];
        bit        r_dir[NR];
        bit [31:0] r_net[NR];
        bit [5:0]  r_plen[NR];
        bit [31:0] r_dist[NR];
        bit [31:0] r_via[NR];
        int        r_tmr[NR];
        bit        f_ok[NF];
        bit [31:0] f_addr[NF];
        bit [31:0] f_net[NF];
        bit [5:0]  f_plen[NF];
        bit [31:0] f_cost[NF];
        int        f_tmr[NF];
        bit        g_ok[NI];
        bit [31:0] g_net[NI];
        t_result   routes_due[$];
        int        fails;
        int        n_results;
        int        n_ops[4];

        function new();
            unreach = RST_UNREACH;
            if_to   = RST_IF_TO;
            del_to  = RST_DEL_TO;
            foreach (r_ok[i]) r_ok[i] = 0;
            foreach (f_ok[i]) f_ok[i] = 0;
            foreach (g_ok[i]) g_ok[i] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, bit [31:0] v);
            case (idx)
                REG_UNREACH:     unreach = v;
                REG_IF_TIMEOUT:  if_to = v[15:0];
                REG_DEL_TIMEOUT: del_to = v[15:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] netmask(bit [5:0] p);
            if (p == 0) return 0;
            if (p > 32) p = 32;
            return 32'hffff_ffff << (32 - p);
        endfunction

        function bit [31:0] sat(bit [63:0] d);
            return (d >= unreach) ? unreach : d[31:0];
        endfunction

        function int route_of(bit [31:0] n);
            for (int i = 0; i < NR; i++) if (r_ok[i] && r_net[i] == n) return i;
            return -1;
        endfunction

        function int free_slot();
            for (int i = 0; i < NR; i++) if (!r_ok[i]) return i;
            return -1;
        endfunction

        function bit ignored(bit [31:0] n);
            for (int i = 0; i < NI; i++) if (g_ok[i] && g_net[i] == n) return 1;
            return 0;
        endfunction

        function void ignore_net(bit [31:0] n);
            if (ignored(n)) return;
            for (int i = 0; i < NI; i++)
                if (!g_ok[i]) begin
                    g_ok[i] = 1;
                    g_net[i] = n;
                    return;
                end
        endfunction

        function void direct_route(int f);
            int r;
            r = route_of(f_net[f]);
            if (r < 0) r = free_slot();
            if (r < 0) return;
            r_ok[r] = 1;
            r_net[r] = f_net[f];
            r_plen[r] = f_plen[f];
            r_dist[r] = sat(f_cost[f]);
            r_dir[r] = 1;
            r_via[r] = 0;
            r_tmr[r] = del_to;
        endfunction

        function void poison(int f, bit down);
            bit hit;
            for (int i = 0; i < NR; i++) begin
                if (!r_ok[i] || r_dist[i] >= unreach) continue;
                hit = !r_dir[i] && ((r_via[i] & netmask(f_plen[f])) == f_net[f]);
                if (down && r_dir[i] && r_net[i] == f_net[f]) hit = 1;
                if (hit) begin
                    r_dist[i] = unreach;
                    r_tmr[i] = del_to;
                end
            end
        endfunction

        function void add_iface(t_item it);
            bit [5:0] p;
            p = (it.prefix_len > 32) ? 6'd32 : it.prefix_len;
            for (int f = 0; f < NF; f++) begin
                if (f_ok[f]) continue;
                f_ok[f] = 1;
                f_addr[f] = it.address;
                f_plen[f] = p;
                f_net[f] = it.address & netmask(p);
                f_cost[f] = it.distance;
                f_tmr[f] = if_to;
                direct_route(f);
                return;
            end
        endfunction

        function void learn(t_item it);
            int nf, r, nr;
            bit [5:0] p, np;
            bit [31:0] s, n, d, nd, total;
            nf = -1;
            nr = -1;
            s = it.address;
            n = it.network;
            d = it.distance;
            p = (it.prefix_len > 32) ? 6'd32 : it.prefix_len;
            for (int f = 0; f < NF; f++) if (f_ok[f] && f_addr[f] == s) return;
            for (int f = 0; f < NF; f++)
                if (f_ok[f] && (s & netmask(f_plen[f])) == f_net[f]) begin
                    nf = f;
                    break;
                end
            if (nf >= 0) f_tmr[nf] = if_to;
            r = route_of(n);
            if (d >= unreach && r < 0) return;
            if (d >= unreach && r_dist[r] >= unreach) begin
                if (ignored(n)) return;
                ignore_net(n);
            end else begin
                for (int i = 0; i < NI; i++) if (g_ok[i] && g_net[i] == n) g_ok[i] = 0;
            end
            nd = (nf >= 0) ? sat(f_cost[nf]) : unreach;
            total = sat(64'(nd) + 64'(d));
            for (int i = 0; i < NR; i++)
                if (r_ok[i] && (s & netmask(r_plen[i])) == r_net[i]) begin
                    nr = i;
                    break;
                end
            if (r >= 0) begin
                r_plen[r] = p;
                if (total < unreach || ignored(n)) r_tmr[r] = del_to;
                if (s == r_via[r]) begin
                    r_dir[r] = 0;
                    r_dist[r] = total;
                end else if (total < r_dist[r]) begin
                    r_dir[r] = 0;
                    r_dist[r] = total;
                    r_via[r] = s;
                end
            end else begin
                r = free_slot();
                if (r >= 0) begin
                    r_ok[r] = 1;
                    r_net[r] = n;
                    r_plen[r] = p;
                    r_dir[r] = 0;
                    r_dist[r] = total;
                    r_via[r] = s;
                    r_tmr[r] = del_to;
                end
            end
            np = (nf >= 0) ? f_plen[nf] : 6'd0;
            if (nr < 0) begin
                nr = free_slot();
                if (nr < 0) return;
                r_ok[nr] = 1;
                r_via[nr] = 0;
                r_tmr[nr] = del_to;
            end
            r_dist[nr] = nd;
            r_dir[nr] = 1;
            r_plen[nr] = np;
            r_net[nr] = s & netmask(np);
        endfunction

        function void age();
            for (int f = 0; f < NF; f++) begin
                if (!f_ok[f]) continue;
                if (f_tmr[f] > 0) f_tmr[f]--;
                if (f_tmr[f] == 0) poison(f, 0);
            end
            for (int i = 0; i < NR; i++) begin
                if (!r_ok[i] || r_dist[i] < unreach) continue;
                if (r_tmr[i] <= 1) begin
                    ignore_net(r_net[i]);
                    r_ok[i] = 0;
                end else begin
                    r_tmr[i]--;
                end
            end
        endfunction

        function void announce(t_item it);
            int f, cnt;
            bit any;
            bit [31:0] dest;
            t_result res;
            f = it.interface_index;
            any = 0;
            cnt = 0;
            if (!f_ok[f]) return;
            for (int i = 0; i < NR; i++) if (r_ok[i]) any = 1;
            if (!any) return;
            if (!it.link_up) begin
                f_tmr[f] = 0;
                poison(f, 1);
                return;
            end
            dest = f_net[f] | ~netmask(f_plen[f]);
            for (int i = 0; i < NR; i++) begin
                if (!r_ok[i]) continue;
                res.route_network = r_net[i];
                res.route_prefix = r_plen[i];
                res.route_distance = (r_dist[i] >= unreach) ? 32'hffff_ffff : r_dist[i];
                res.destination = dest;
                res.last = 0;
                routes_due.push_back(res);
                cnt++;
                direct_route(f);
            end
            if (cnt > 0) routes_due[$].last = 1;
        endfunction

        function void note_item(t_item it);
            n_ops[it.operation]++;
            case (it.operation)
                OP_ADD_IF: add_iface(it);
                OP_ADVERT: learn(it);
                OP_TICK:   age();
                OP_SEND:   announce(it);
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result want;
            n_results++;
            if (routes_due.size() == 0) begin
                $error("unexpected route result %p", got);
                fails++;
                return;
            end
            want = routes_due.pop_front();
            if (got.route_network !== want.route_network) begin
                $error("route_network: expected %h, got %h", want.route_network, got.route_network);
                fails++;
            end
            if (got.route_prefix !== want.route_prefix) begin
                $error("route_prefix: expected %0d, got %0d", want.route_prefix, got.route_prefix);
                fails++;
            end
            if (got.route_distance !== want.route_distance) begin
                $error("route_distance: expected %h, got %h",
                       want.route_distance, got.route_distance);
                fails++;
            end
            if (got.destination !== want.destination) begin
                $error("destination: expected %h, got %h", want.destination, got.destination);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %b, got %b", want.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    t_item       i_item = '0;
    logic        o_result_valid;
    t_result     o_result;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    route_scoreboard sb;
    int              gap_pct;

    distance_vector_route_table_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_result_valid(o_result_valid), .o_result(o_result), .psel(psel),
        .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_result);
    end

    task automatic send(t_item it);
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || sb.routes_due.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic t_item noise();
        t_item it;
        it.operation = t_op'($urandom_range(3));
        it.address = $urandom;
        it.network = $urandom;
        it.prefix_len = $urandom_range(63);
        it.distance = $urandom;
        it.interface_index = $urandom_range(7);
        it.link_up = $urandom_range(1);
        return it;
    endfunction

    function automatic t_item op_item(t_op op, bit [31:0] a, bit [31:0] n, bit [5:0] p,
                                      bit [31:0] d, bit [2:0] f, bit up);
        t_item it;
        it.operation = op;
        it.address = a;
        it.network = n;
        it.prefix_len = p;
        it.distance = d;
        it.interface_index = f;
        it.link_up = up;
        return it;
    endfunction

    function automatic t_item shaped_item();
        int pick;
        bit [31:0] sndr, nw, d;
        pick = $urandom_range(99);
        sndr = {8'd10, 8'($urandom_range(7)), 8'd0, 8'($urandom_range(1, 4))};
        nw = ($urandom_range(3) == 0) ? {8'd10, 8'($urandom_range(7)), 16'd0}
                                       : {8'd20, 8'($urandom_range(15)), 16'd0};
        d = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 20);
        if (pick < 6)
            return noise();
        if (pick < 14)
            return op_item(OP_ADD_IF, {8'd10, 8'($urandom_range(7)), 16'd1}, $urandom,
                           ($urandom_range(3) == 0) ? 6'($urandom_range(33)) : 6'd24,
                           $urandom_range(0, 4), $urandom, $urandom_range(1));
        if (pick < 55)
            return op_item(OP_ADVERT, sndr, nw,
                           ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'd16,
                           d, $urandom, $urandom_range(1));
        if (pick < 77)
            return op_item(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(1));
        return op_item(OP_SEND, $urandom, $urandom, $urandom, $urandom, $urandom_range(7),
                       $urandom_range(9) != 0);
    endfunction

    initial begin
        sb = new();
        gap_pct = 19;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(op_item(OP_SEND, 0, 0, 0, 0, 3'd0, 1'b1));
        send(op_item(OP_ADVERT, 32'h0a00_0002, 32'h1400_0000, 6'd16, 32'd3, 0, 0));
        send(op_item(OP_ADD_IF, 32'h0a00_0001, 0, 6'd24, 32'd1, 0, 0));
        send(op_item(OP_ADD_IF, 32'hffff_ffff, 0, 6'd0, 32'd0, 0, 0));
        send(op_item(OP_ADD_IF, 32'h0a01_0001, 0, 6'd63, 32'hffff_ffff, 0, 0));
        send(op_item(OP_ADD_IF, 32'h0a02_0001, 0, 6'd32, 32'd2, 0, 0));
        send(op_item(OP_ADVERT, 32'h0a00_0001, 32'h1400_0000, 6'd16, 32'd1, 0, 0));
        send(op_item(OP_ADVERT, 32'h0a00_0002, 32'h1400_0000, 6'd16, 32'd0, 0, 0));
        send(op_item(OP_ADVERT, 32'h0a00_0003, 32'h1400_0000, 6'd16, 32'd2, 0, 0));
        send(op_item(OP_ADVERT, 32'h0a00_0002, 32'h1500_0000, 6'd40, 32'hffff_ffff, 0, 0));
        send(op_item(OP_ADVERT, 32'hc0a8_0001, 32'h1600_0000, 6'd8, 32'd1, 0, 0));
        send(op_item(OP_SEND, 0, 0, 0, 0, 3'd0, 1'b1));
        send(op_item(OP_SEND, 0, 0, 0, 0, 3'd7, 1'b1));
        send(op_item(OP_SEND, 0, 0, 0, 0, 3'd1, 1'b1));
        send(op_item(OP_SEND, 0, 0, 0, 0, 3'd0, 1'b0));
        for (int i = 0; i < 6; i++) send(op_item(OP_TICK, 0, 0, 0, 0, 0, 0));
        send(op_item(OP_ADVERT, 32'h0a00_0002, 32'h1400_0000, 6'd16, 32'd16, 0, 0));
        send(op_item(OP_SEND, 0, 0, 0, 0, 3'd2, 1'b1));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_UNREACH, 32'd1);
                    write_reg(REG_IF_TIMEOUT, 32'd1);
                    write_reg(REG_DEL_TIMEOUT, 32'd1);
                end
                1: begin
                    write_reg(REG_UNREACH, 32'hffff_ffff);
                    write_reg(REG_IF_TIMEOUT, 32'd65535);
                    write_reg(REG_DEL_TIMEOUT, 32'd65535);
                end
                2: begin
                    write_reg(REG_UNREACH, $urandom_range(8, 40));
                    write_reg(REG_IF_TIMEOUT, $urandom_range(2, 6));
                    write_reg(REG_DEL_TIMEOUT, $urandom_range(1, 4));
                end
                default: begin
                    write_reg(REG_UNREACH, 32'd16);
                    write_reg(REG_IF_TIMEOUT, 32'd5);
                    write_reg(REG_DEL_TIMEOUT, 32'd5);
                end
            endcase
            gap_pct = (ph < 2) ? 19 : (ph == 2) ? 56 : 0;
            for (int k = 0; k < 70; k++) send(shaped_item());
            drain();
        end

        $display("Covered %0d add_interface, %0d advert, %0d tick and %0d advertise items,",
                 sb.n_ops[0], sb.n_ops[1], sb.n_ops[2], sb.n_ops[3]);
        $display("checking %0d route results over five register settings.", sb.n_results);
        if (sb.fails == 0 && sb.routes_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/dvrt_pkg.sv
design/dvrt_sat_unit.sv
design/distance_vector_route_table_top.sv
test/distance_vector_route_table_top_tb.sv
